/* rtl/core/ppp_pkg.sv */
// Shared types, widths and helper functions for the pinhole point projector.
// Used by pinhole_point_projector_top; has no dependencies of its own.

package ppp_pkg;

  localparam int CoordW    = 32;                  // Q16.16 point coordinates
  localparam int FocalW    = 24;                  // unsigned focal length
  localparam int CenterW   = 24;                  // signed principal point
  localparam int SizeW     = 16;                  // image width and height
  localparam int FineW     = 32;                  // subpixel output
  localparam int PixW      = 24;                  // integer pixel output
  localparam int ProdW     = 55;                  // |focal * coord| < 2^55
  localparam int DivisorW  = 32;                  // |point_z| <= 2^31
  localparam int SumW      = ProdW + 2;           // signed quotient plus center
  localparam int RoundW    = FineW + 2;           // 2*fine + half, signed
  localparam int InDataW   = 3 * CoordW;
  localparam int OutDataW  = 2 * FineW + 2 * PixW;

  localparam logic [FineW-1:0] FineMax = {1'b0, {(FineW-1){1'b1}}};
  localparam logic [FineW-1:0] FineMin = {1'b1, {(FineW-1){1'b0}}};
  localparam logic [PixW-1:0]  PixMax  = {1'b0, {(PixW-1){1'b1}}};
  localparam logic [PixW-1:0]  PixMin  = {1'b1, {(PixW-1){1'b0}}};

  typedef enum logic [2:0] {
    CfgFocalX      = 3'd0,
    CfgFocalY      = 3'd1,
    CfgCenterX     = 3'd2,
    CfgCenterY     = 3'd3,
    CfgImageWidth  = 3'd4,
    CfgImageHeight = 3'd5
  } cfg_reg_e;

  // Per-point flags that ride along with the divider
  typedef struct packed {
    logic sign_x;
    logic sign_y;
    logic sign_z;
    logic zero_z;
    logic nz_u;   // focal_x * x is nonzero
    logic nz_v;   // focal_y * y is nonzero
  } side_t;

  // Restoring divider word: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [DivisorW-1:0] rem;
    logic [ProdW-1:0]    dq;
  } div_word_t;

  function automatic div_word_t div_step(div_word_t w, logic [DivisorW-1:0] d);
    logic [DivisorW:0] t;
    logic [DivisorW:0] diff;
    div_word_t         r;
    t    = {w.rem, w.dq[ProdW-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r.rem = diff[DivisorW-1:0];
      r.dq  = {w.dq[ProdW-2:0], 1'b1};
    end else begin
      r.rem = t[DivisorW-1:0];
      r.dq  = {w.dq[ProdW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [FineW-1:0] sat_fine(logic [SumW-1:0] s);
    logic fits;
    fits = (s[SumW-1:FineW-1] == {(SumW-FineW+1){s[SumW-1]}});
    if (fits) begin
      return s[FineW-1:0];
    end else if (s[SumW-1]) begin
      return FineMin;
    end else begin
      return FineMax;
    end
  endfunction

  function automatic logic [PixW-1:0] sat_pix(logic [RoundW-1:0] s);
    logic fits;
    fits = (s[RoundW-1:PixW-1] == {(RoundW-PixW+1){s[RoundW-1]}});
    if (fits) begin
      return s[PixW-1:0];
    end else if (s[RoundW-1]) begin
      return PixMin;
    end else begin
      return PixMax;
    end
  endfunction

endpackage

/* rtl/core/pinhole_point_projector_top.sv */
// Pinhole point projector: streaming top level with configuration registers.
// Depends on ppp_pkg for widths, the divider step and saturation helpers.

// Takes one point per cycle and returns its projection. The pipeline depth
// is set by the 55-step restoring divider that forms focal*coord/z,
// one quotient bit per register stage for both axes in parallel; around it sit
// an abs stage, a 24x32 multiply stage, a negate stage, a center add with
// saturation, two rounding stages and the output register. A one-entry skid
// buffer sits behind the output register; the whole pipe stalls only while
// that entry is occupied, so one point per cycle flows while results are taken.
// Configuration must be written only when no point is in flight.

module pinhole_point_projector_top #(
  parameter int unsigned PixelFracBits = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // point_x, point_y, point_z
  input  logic [ppp_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pixel_u_fine, pixel_v_fine, pixel_u, pixel_v
  output logic [ppp_pkg::OutDataW-1:0] m_axis_tdata,
  // in_image
  output logic                         m_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [ppp_pkg::FocalW-1:0]   cfg_data_i
);

  localparam int DivSteps = ppp_pkg::ProdW;
  localparam int CoordW   = ppp_pkg::CoordW;
  localparam int FocalW   = ppp_pkg::FocalW;
  localparam int FineW    = ppp_pkg::FineW;
  localparam int PixW     = ppp_pkg::PixW;
  localparam int RoundW   = ppp_pkg::RoundW;
  localparam int SumW     = ppp_pkg::SumW;
  localparam logic [RoundW-1:0] Half      = RoundW'(1) << PixelFracBits;
  localparam logic [RoundW-1:0] RoundMask = (RoundW'(1) << (PixelFracBits + 1)) - RoundW'(1);

  // ---------------------------------------------------------------- config
  logic [FocalW-1:0]            focal_x_q, focal_y_q;
  logic [ppp_pkg::CenterW-1:0]  center_x_q, center_y_q;
  logic [ppp_pkg::SizeW-1:0]    width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 24'd134400;
      focal_y_q  <= 24'd134400;
      center_x_q <= 24'd81792;
      center_y_q <= 24'd61312;
      width_q    <= 16'd640;
      height_q   <= 16'd480;
    end else if (cfg_valid_i) begin
      case (ppp_pkg::cfg_reg_e'(cfg_index_i))
        ppp_pkg::CfgFocalX:      focal_x_q  <= cfg_data_i;
        ppp_pkg::CfgFocalY:      focal_y_q  <= cfg_data_i;
        ppp_pkg::CfgCenterX:     center_x_q <= cfg_data_i;
        ppp_pkg::CfgCenterY:     center_y_q <= cfg_data_i;
        ppp_pkg::CfgImageWidth:  width_q    <= cfg_data_i[ppp_pkg::SizeW-1:0];
        ppp_pkg::CfgImageHeight: height_q   <= cfg_data_i[ppp_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic skid_valid_q;
  logic out_valid_q;
  logic adv;

  // the whole pipe moves unless the skid entry is occupied
  assign adv           = !skid_valid_q;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------- abs stage
  logic [CoordW-1:0] in_x, in_y, in_z;
  logic              a_valid_q;
  logic [CoordW-1:0] a_mag_x_q, a_mag_y_q, a_mag_z_q;
  ppp_pkg::side_t    a_side_q;

  assign in_x = s_axis_tdata[CoordW-1:0];
  assign in_y = s_axis_tdata[2*CoordW-1:CoordW];
  assign in_z = s_axis_tdata[3*CoordW-1:2*CoordW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_mag_x_q       <= in_x[CoordW-1] ? (~in_x + 1'b1) : in_x;
      a_mag_y_q       <= in_y[CoordW-1] ? (~in_y + 1'b1) : in_y;
      a_mag_z_q       <= in_z[CoordW-1] ? (~in_z + 1'b1) : in_z;
      a_side_q.sign_x <= in_x[CoordW-1];
      a_side_q.sign_y <= in_y[CoordW-1];
      a_side_q.sign_z <= in_z[CoordW-1];
      a_side_q.zero_z <= (in_z == '0);
      a_side_q.nz_u   <= (in_x != '0);
      a_side_q.nz_v   <= (in_y != '0);
    end
  end

  // ---------------------------------------------------------------- multiply + divide
  logic [FocalW+CoordW-1:0]      prod_u, prod_v;
  ppp_pkg::side_t                a_side_d;
  logic [DivSteps:0]             dv_q;
  ppp_pkg::div_word_t            dw_u_q [DivSteps+1];
  ppp_pkg::div_word_t            dw_v_q [DivSteps+1];
  logic [ppp_pkg::DivisorW-1:0]  dvs_q  [DivSteps+1];
  ppp_pkg::side_t                dside_q[DivSteps+1];

  assign prod_u = {{CoordW{1'b0}}, focal_x_q} * {{FocalW{1'b0}}, a_mag_x_q};
  assign prod_v = {{CoordW{1'b0}}, focal_y_q} * {{FocalW{1'b0}}, a_mag_y_q};

  // a zero focal length makes the product zero whatever the sign
  always_comb begin
    a_side_d      = a_side_q;
    a_side_d.nz_u = a_side_q.nz_u && (focal_x_q != '0);
    a_side_d.nz_v = a_side_q.nz_v && (focal_y_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dw_u_q[0].rem      <= '0;
      dw_u_q[0].dq       <= prod_u[DivSteps-1:0];
      dw_v_q[0].rem      <= '0;
      dw_v_q[0].dq       <= prod_v[DivSteps-1:0];
      dvs_q[0]           <= a_mag_z_q;
      dside_q[0]         <= a_side_d;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dw_u_q[k+1]  <= ppp_pkg::div_step(dw_u_q[k], dvs_q[k]);
        dw_v_q[k+1]  <= ppp_pkg::div_step(dw_v_q[k], dvs_q[k]);
        dvs_q[k+1]   <= dvs_q[k];
        dside_q[k+1] <= dside_q[k];
      end
    end
  end

  // ---------------------------------------------------------------- negate stage
  logic [DivSteps:0] q_u_ext, q_v_ext;
  logic              n_valid_q;
  logic [DivSteps:0] n_qs_u_q, n_qs_v_q;
  ppp_pkg::side_t    n_side_q;

  assign q_u_ext = {1'b0, dw_u_q[DivSteps].dq};
  assign q_v_ext = {1'b0, dw_v_q[DivSteps].dq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else if (adv) begin
      n_valid_q <= dv_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_qs_u_q <= (dside_q[DivSteps].sign_x ^ dside_q[DivSteps].sign_z)
                  ? (~q_u_ext + 1'b1) : q_u_ext;
      n_qs_v_q <= (dside_q[DivSteps].sign_y ^ dside_q[DivSteps].sign_z)
                  ? (~q_v_ext + 1'b1) : q_v_ext;
      n_side_q <= dside_q[DivSteps];
    end
  end

  // ---------------------------------------------------------------- center add
  logic [SumW-1:0]  sum_u, sum_v;
  logic [FineW-1:0] fine_u_d, fine_v_d;
  logic             f_valid_q, f_zero_z_q;
  logic [FineW-1:0] f_fine_u_q, f_fine_v_q;

  assign sum_u = {n_qs_u_q[DivSteps], n_qs_u_q}
               + {{(SumW-ppp_pkg::CenterW){center_x_q[ppp_pkg::CenterW-1]}}, center_x_q};
  assign sum_v = {n_qs_v_q[DivSteps], n_qs_v_q}
               + {{(SumW-ppp_pkg::CenterW){center_y_q[ppp_pkg::CenterW-1]}}, center_y_q};

  // zero depth: saturate by the sign of the product
  always_comb begin
    if (n_side_q.zero_z) begin
      fine_u_d = (n_side_q.sign_x && n_side_q.nz_u) ? ppp_pkg::FineMin : ppp_pkg::FineMax;
      fine_v_d = (n_side_q.sign_y && n_side_q.nz_v) ? ppp_pkg::FineMin : ppp_pkg::FineMax;
    end else begin
      fine_u_d = ppp_pkg::sat_fine(sum_u);
      fine_v_d = ppp_pkg::sat_fine(sum_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (adv) begin
      f_valid_q <= n_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_fine_u_q <= fine_u_d;
      f_fine_v_q <= fine_v_d;
      f_zero_z_q <= n_side_q.zero_z;
    end
  end

  // ---------------------------------------------------------------- rounding
  logic              r1_valid_q, r1_zero_z_q;
  logic [FineW-1:0]  r1_fine_u_q, r1_fine_v_q;
  logic [RoundW-1:0] r1_tw_u_q, r1_tw_v_q;
  logic signed [RoundW-1:0] adj_u, adj_v, shr_u, shr_v;
  logic              r2_valid_q, r2_zero_z_q;
  logic [FineW-1:0]  r2_fine_u_q, r2_fine_v_q;
  logic [PixW-1:0]   r2_pix_u_q, r2_pix_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
      r2_valid_q <= 1'b0;
    end else if (adv) begin
      r1_valid_q <= f_valid_q;
      r2_valid_q <= r1_valid_q;
    end
  end

  // twice the fine value plus one half, in units of 2^-(P+1)
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_tw_u_q   <= {f_fine_u_q[FineW-1], f_fine_u_q, 1'b0} + Half;
      r1_tw_v_q   <= {f_fine_v_q[FineW-1], f_fine_v_q, 1'b0} + Half;
      r1_fine_u_q <= f_fine_u_q;
      r1_fine_v_q <= f_fine_v_q;
      r1_zero_z_q <= f_zero_z_q;
    end
  end

  // bias negatives so the arithmetic shift truncates toward zero
  assign adj_u = r1_tw_u_q + (r1_tw_u_q[RoundW-1] ? RoundMask : '0);
  assign adj_v = r1_tw_v_q + (r1_tw_v_q[RoundW-1] ? RoundMask : '0);
  assign shr_u = adj_u >>> (PixelFracBits + 1);
  assign shr_v = adj_v >>> (PixelFracBits + 1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_pix_u_q  <= ppp_pkg::sat_pix(shr_u);
      r2_pix_v_q  <= ppp_pkg::sat_pix(shr_v);
      r2_fine_u_q <= r1_fine_u_q;
      r2_fine_v_q <= r1_fine_v_q;
      r2_zero_z_q <= r1_zero_z_q;
    end
  end

  // ---------------------------------------------------------------- output + skid
  logic                         item_in_image;
  logic [ppp_pkg::OutDataW-1:0] item_data;
  logic [ppp_pkg::OutDataW-1:0] out_tdata_q, skid_tdata_q;
  logic                         out_tuser_q, skid_tuser_q;
  logic                         pop;

  assign item_in_image = !r2_zero_z_q
                      && !r2_pix_u_q[PixW-1] && !r2_pix_v_q[PixW-1]
                      && ({1'b0, r2_pix_u_q[PixW-2:0]} <
                          {{(PixW-ppp_pkg::SizeW){1'b0}}, width_q})
                      && ({1'b0, r2_pix_v_q[PixW-2:0]} <
                          {{(PixW-ppp_pkg::SizeW){1'b0}}, height_q});
  assign item_data = {r2_pix_v_q, r2_pix_u_q, r2_fine_v_q, r2_fine_u_q};
  assign pop       = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (r2_valid_q) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_tdata_q <= skid_tdata_q;
        out_tuser_q <= skid_tuser_q;
      end
    end else if (r2_valid_q) begin
      if (out_valid_q && !pop) begin
        skid_tdata_q <= item_data;
        skid_tuser_q <= item_in_image;
      end else begin
        out_tdata_q <= item_data;
        out_tuser_q <= item_in_image;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

  // ---------------------------------------------------------------- checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a pending output");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid entry filled while output was free");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DivSteps] && (dvs_q[DivSteps] != '0) |->
      (dw_u_q[DivSteps].rem < dvs_q[DivSteps]) &&
      (dw_v_q[DivSteps].rem < dvs_q[DivSteps]))
    else $error("divider remainder not below divisor");

  a_inside_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_tuser_q |->
      !out_tdata_q[2*FineW+PixW-1] && !out_tdata_q[2*FineW+2*PixW-1])
    else $error("in-image flag set on a negative pixel");

endmodule
